// ===== sv/a2u_pkg.sv =====
// Shared types and constants for the ASN.1 string to UTF-8 transcoder.
package a2u_pkg;

    localparam logic [7:0] TAG_UTF8  = 8'd12;
    localparam logic [7:0] TAG_BMP   = 8'd30;
    localparam logic [7:0] TAG_UNIV  = 8'd28;
    localparam logic [7:0] TAG_PRINT = 8'd19;
    localparam logic [7:0] TAG_T61   = 8'd20;
    localparam logic [7:0] TAG_IA5   = 8'd22;

    localparam logic [31:0] CP_ONE_MAX   = 32'h0000_007F;
    localparam logic [31:0] CP_TWO_MAX   = 32'h0000_07FF;
    localparam logic [31:0] CP_THREE_MAX = 32'h0000_FFFF;
    localparam logic [31:0] CP_SURR_LO   = 32'h0000_D800;
    localparam logic [31:0] CP_SURR_HI   = 32'h0000_DFFF;
    localparam logic [31:0] CP_MAX       = 32'h0010_FFFF;

    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;

    localparam int IDX_W    = 7;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;

    // One decoded item: the UTF-8 bytes it stores and the optional string-end result.
    typedef struct packed {
        logic [3:0][7:0]  enc;
        logic [2:0]       nb;
        logic [IDX_W-1:0] base;
        logic             done;
        logic             status;
        logic [IDX_W-1:0] size;
    } job_t;

    // Queue to back end handshake.
    typedef struct packed {
        logic valid;
        logic pop;
    } q_ctl_t;

endpackage

// ===== sv/asn1_string_to_utf8_transcoder.sv =====
// Top level of the ASN.1 string to UTF-8 transcoder.
// Takes one content byte of an ASN.1 string per item (tag and end marks in tuser/tlast) and
// emits the UTF-8 text one byte per result, followed by one string-end result with status and
// size. The front end decodes an item in the cycle it is accepted and takes a new item every
// cycle while its four-entry job queue has room; the back end sends exactly one result per
// cycle from its output register while results wait and the receiver is ready. An item yields
// zero to five results, so the single output port sets the sustained item rate; plain ASCII
// runs at one item per cycle when the receiver does not stall. The first result passes through
// the job queue and then the output register before it is presented.
module asn1_string_to_utf8_transcoder
    import a2u_pkg::*;
#(
    parameter int OUT_CAPACITY = 127
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tlast,
    input  logic [8:0]  s_axis_tuser,   // asn1_tag[7:0], empty_string[8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_byte[7:0], out_index[14:8], status[15],
                                        // total_size[22:16], zero[23]
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // byte_valid[0], done_res[1]
);

    logic   q_full;
    logic   push;
    job_t   job_in;
    job_t   job_head;
    logic   q_not_empty;
    q_ctl_t q_ctl;

    a2u_front #(
        .OUT_CAPACITY(OUT_CAPACITY)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_axis_tvalid),
        .item_ready (s_axis_tready),
        .item_tag   (s_axis_tuser[7:0]),
        .item_data  (s_axis_tdata),
        .item_last  (s_axis_tlast),
        .item_empty (s_axis_tuser[8]),
        .q_full     (q_full),
        .push       (push),
        .job        (job_in)
    );

    a2u_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .job_in    (job_in),
        .full      (q_full),
        .ctl_in    (q_ctl),
        .not_empty (q_not_empty),
        .job_out   (job_head)
    );

    a2u_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_not_empty),
        .job           (job_head),
        .q_ctl         (q_ctl),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== sv/a2u_front.sv =====
// Front end: accepts items, decodes units, encodes code points, tracks string state.
module a2u_front
    import a2u_pkg::*;
#(
    parameter int OUT_CAPACITY = 127
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] item_tag,
    input  logic [7:0] item_data,
    input  logic       item_last,
    input  logic       item_empty,
    input  logic       q_full,
    output logic       push,
    output job_t       job
);

    localparam int CNT_W = $clog2(OUT_CAPACITY + 1);
    localparam int CMP_W = CNT_W + 3;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(OUT_CAPACITY);

    logic [31:0]      acc_reg, acc_next;
    logic [2:0]       gp_reg, gp_next;
    logic [2:0]       gl_reg, gl_next;
    logic [CNT_W-1:0] wc_reg, wc_next;
    logic             err_reg, err_next;

    logic             accept;
    logic             fail;
    logic             emit_cp;
    logic [31:0]      cp;
    logic [31:0]      acc_new;
    logic [2:0]       gp_inc;
    logic [2:0]       len;
    logic [3:0][7:0]  enc;
    logic [CNT_W-1:0] room;
    logic [2:0]       nb;
    logic             ending;
    logic             err_fin;
    logic             is_utf8, is_wide, is_single, tag_known;

    assign accept     = item_valid && !q_full;
    assign item_ready = !q_full;

    always_comb
    begin
        is_utf8   = (item_tag == TAG_UTF8);
        is_wide   = (item_tag == TAG_BMP) || (item_tag == TAG_UNIV);
        is_single = (item_tag == TAG_PRINT) || (item_tag == TAG_T61) || (item_tag == TAG_IA5);
        tag_known = is_utf8 || is_wide || is_single;

        acc_next = acc_reg;
        gp_next  = gp_reg;
        gl_next  = gl_reg;
        fail     = 1'b0;
        emit_cp  = 1'b0;
        cp       = '0;
        acc_new  = acc_reg;
        gp_inc   = gp_reg + 3'd1;

        if (!item_empty && !err_reg)
        begin
            if (is_utf8 && gp_reg == 3'd0)
            begin
                if (item_data <= CP_ONE_MAX[7:0])
                begin
                    emit_cp = 1'b1;
                    cp      = {24'd0, item_data};
                end
                else if (item_data inside {[LEAD2_LO:LEAD2_HI]})
                begin
                    acc_next = {27'd0, item_data[4:0]};
                    gl_next  = 3'd2;
                    gp_next  = 3'd1;
                end
                else if (item_data inside {[LEAD3_LO:LEAD3_HI]})
                begin
                    acc_next = {28'd0, item_data[3:0]};
                    gl_next  = 3'd3;
                    gp_next  = 3'd1;
                end
                else if (item_data inside {[LEAD4_LO:LEAD4_HI]})
                begin
                    acc_next = {29'd0, item_data[2:0]};
                    gl_next  = 3'd4;
                    gp_next  = 3'd1;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            else if (is_wide && gp_reg == 3'd0)
            begin
                acc_next = {24'd0, item_data};
                gl_next  = (item_tag == TAG_BMP) ? 3'd2 : 3'd4;
                gp_next  = 3'd1;
            end
            else if (is_single && gp_reg == 3'd0)
            begin
                emit_cp = 1'b1;
                cp      = {24'd0, item_data};
            end
            else if ((is_utf8 && item_data[7:6] == 2'b10) || is_wide)
            begin
                // continuation of a unit already begun
                acc_new  = is_utf8 ? {acc_reg[25:0], item_data[5:0]}
                                   : {acc_reg[23:0], item_data};
                acc_next = acc_new;
                if (gp_inc < gl_reg)
                begin
                    gp_next = gp_inc;
                end
                else
                begin
                    gp_next = 3'd0;
                    if (is_utf8 && ((gl_reg == 3'd2 && acc_new <= CP_ONE_MAX) ||
                                    (gl_reg == 3'd3 && acc_new <= CP_TWO_MAX) ||
                                    (gl_reg == 3'd4 && acc_new <= CP_THREE_MAX)))
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        emit_cp = 1'b1;
                        cp      = acc_new;
                    end
                end
            end
            else
            begin
                fail = 1'b1;
            end
        end
    end

    // UTF-8 encoder
    always_comb
    begin
        enc = '0;
        len = 3'd0;
        if (emit_cp)
        begin
            if (cp <= CP_ONE_MAX)
            begin
                enc[0] = cp[7:0];
                len    = 3'd1;
            end
            else if (cp <= CP_TWO_MAX)
            begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
                len    = 3'd2;
            end
            else if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
            begin
                len = 3'd0;
            end
            else if (cp <= CP_THREE_MAX)
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
                len    = 3'd3;
            end
            else if (cp <= CP_MAX)
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
                len    = 3'd4;
            end
            else
            begin
                len = 3'd0;
            end
        end
    end

    always_comb
    begin
        logic bad;
        bad  = fail || (emit_cp && len == 3'd0);
        room = CAP - wc_reg;
        if (bad)
            nb = 3'd0;
        else if (CMP_W'(len) <= CMP_W'(room))
            nb = len;
        else
            nb = 3'(room);

        wc_next  = wc_reg + CNT_W'(nb);
        err_next = err_reg || bad;
        ending   = item_empty || item_last;
        err_fin  = err_next || (gp_next != 3'd0) || (item_empty && !tag_known);

        job.enc    = enc;
        job.nb     = nb;
        job.base   = IDX_W'(wc_reg);
        job.done   = ending;
        job.status = ending && err_fin;
        job.size   = (ending && !err_fin) ? IDX_W'(wc_next) : '0;
        push       = accept && (nb != 3'd0 || ending);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            gp_reg  <= '0;
            gl_reg  <= '0;
            wc_reg  <= '0;
            err_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (ending)
            begin
                acc_reg <= '0;
                gp_reg  <= '0;
                gl_reg  <= '0;
                wc_reg  <= '0;
                err_reg <= 1'b0;
            end
            else
            begin
                acc_reg <= acc_next;
                gp_reg  <= gp_next;
                gl_reg  <= gl_next;
                wc_reg  <= wc_next;
                err_reg <= err_next;
            end
        end
    end

endmodule

// ===== sv/a2u_queue.sv =====
// Short job queue between the decode front end and the output back end.
module a2u_queue
    import a2u_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  job_t   job_in,
    output logic   full,
    input  q_ctl_t ctl_in,
    output logic   not_empty,
    output job_t   job_out
);

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic              pop;

    assign full      = (cnt_reg == (QPTR_W + 1)'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop       = ctl_in.pop && not_empty;
    assign job_out   = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem[wr_reg] <= job_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            case ({push && !full, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ===== sv/a2u_back.sv =====
// Back end: walks queued jobs, one result per cycle via an output register unless stalled.
module a2u_back
    import a2u_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  job_t         job,
    output q_ctl_t       q_ctl,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    output logic [1:0]   m_axis_tuser
);

    logic [2:0]       pos_reg;
    logic             ovalid_reg;
    logic [23:0]      odata_reg;
    logic             olast_reg;
    logic [1:0]       ouser_reg;

    logic             advance;
    logic             is_byte;
    logic             res_last;
    logic [IDX_W-1:0] res_idx;
    logic [23:0]      res_data;
    logic [1:0]       res_user;

    assign advance = q_valid && (!ovalid_reg || m_axis_tready);

    always_comb
    begin
        is_byte = (pos_reg < job.nb);
        res_idx = job.base + IDX_W'(pos_reg);
        if (is_byte)
        begin
            res_data = {1'b0, IDX_W'(0), 1'b0, res_idx, job.enc[pos_reg[1:0]]};
            res_user = 2'b01;
            res_last = (pos_reg + 3'd1 == job.nb) && !job.done;
        end
        else
        begin
            res_data = {1'b0, job.size, job.status, IDX_W'(0), 8'd0};
            res_user = 2'b10;
            res_last = 1'b1;
        end
        q_ctl.valid = q_valid;
        q_ctl.pop   = advance && res_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                ovalid_reg <= 1'b1;
                pos_reg    <= res_last ? 3'd0 : pos_reg + 3'd1;
            end
            else if (m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            odata_reg <= res_data;
            olast_reg <= res_last;
            ouser_reg <= res_user;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tuser  = ouser_reg;

endmodule

// ===== sv/a2u_checker.sv =====
// Port-level checks for the transcoder and the bind that attaches them.
module a2u_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [1:0]  m_axis_tuser
);

    // a result is either a byte or a string end, never both
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot(m_axis_tuser))
        else $error("result kind not one-hot");

    // string end always closes the item's run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && m_axis_tdata[14:0] == 15'd0)
        else $error("string-end result malformed");

    // malformed strings report no size; byte results carry no status or size
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] || m_axis_tdata[15]) |-> m_axis_tdata[22:16] == 7'd0)
        else $error("size reported with error or on byte result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind asn1_string_to_utf8_transcoder a2u_checker u_a2u_checker (.*);

// ===== bench/tb_asn1_string_to_utf8_transcoder.sv =====
// Self-checking testbench for the ASN.1 string to UTF-8 transcoder.
module tb_asn1_string_to_utf8_transcoder;
    import a2u_pkg::*;

    localparam int CAPACITY = 127;
    localparam int RAND_ITEMS = 125;
    localparam int QUIET_TAIL = 30;
    localparam logic [7:0] TAG_UNKNOWN_LO = 8'h05;
    localparam logic [7:0] TAG_UNKNOWN_HI = 8'hFF;

    // One result of the block, fields as carried on the master side.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [6:0] out_index;
        logic       byte_valid;
        logic       last_of_run;
        logic       done_res;
        logic       status;
        logic [6:0] total_size;
    } utf8_res_t;

    // One input item: a content byte with its tag and end marks.
    typedef struct packed {
        logic [7:0] tag;
        logic [7:0] data;
        logic       last;
        logic       empty;
    } str_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // in_byte
    logic        s_axis_tlast;
    logic [8:0]  s_axis_tuser;   // asn1_tag[7:0], empty_string[8]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // out_byte[7:0], out_index[14:8], status[15],
                                 // total_size[22:16], zero[23]
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;   // byte_valid[0], done_res[1]

    // Decoder state mirrored from the block.
    logic [31:0] acc_cp;
    logic [2:0]  unit_pos;
    logic [2:0]  unit_len;
    logic [6:0]  out_count;
    logic        str_bad;

    utf8_res_t utf8_expect_q[$];
    utf8_res_t run_q[$];
    str_item_t stim_q[$];

    int  mismatch_count;
    int  items_sent;
    bit  idle_on;

    asn1_string_to_utf8_transcoder #(
        .OUT_CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    // Returns the number of UTF-8 bytes, 0 for a surrogate or out-of-range value.
    function automatic int utf8_encode(input logic [31:0] cp, output logic [31:0] enc);
        enc = '0;
        if (cp <= CP_ONE_MAX)
        begin
            enc[7:0] = cp[7:0];
            return 1;
        end
        if (cp <= CP_TWO_MAX)
        begin
            enc[7:0]  = {3'b110, cp[10:6]};
            enc[15:8] = {2'b10, cp[5:0]};
            return 2;
        end
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
            return 0;
        if (cp <= CP_THREE_MAX)
        begin
            enc[7:0]   = {4'b1110, cp[15:12]};
            enc[15:8]  = {2'b10, cp[11:6]};
            enc[23:16] = {2'b10, cp[5:0]};
            return 3;
        end
        if (cp <= CP_MAX)
        begin
            enc[7:0]   = {5'b11110, cp[20:18]};
            enc[15:8]  = {2'b10, cp[17:12]};
            enc[23:16] = {2'b10, cp[11:6]};
            enc[31:24] = {2'b10, cp[5:0]};
            return 4;
        end
        return 0;
    endfunction

    task automatic reset_decoder();
        acc_cp    = '0;
        unit_pos  = '0;
        unit_len  = '0;
        out_count = '0;
        str_bad   = 1'b0;
    endtask

    task automatic store_code_point(input logic [31:0] cp, output bit bad);
        logic [31:0] enc;
        utf8_res_t   r;
        int          len;
        len = utf8_encode(cp, enc);
        bad = (len == 0);
        for (int i = 0; i < len; i++)
        begin
            // bytes past the buffer end are dropped silently
            if (out_count < CAPACITY)
            begin
                r = '0;
                r.out_byte   = enc[8*i +: 8];
                r.out_index  = out_count;
                r.byte_valid = 1'b1;
                run_q.push_back(r);
                out_count++;
            end
        end
    endtask

    task automatic take_content_byte(input logic [7:0] tag, input logic [7:0] b,
                                     output bit bad);
        bad = 1'b0;
        if (tag == TAG_UTF8)
        begin
            if (unit_pos == 0)
            begin
                if (b <= 8'h7F)
                begin
                    store_code_point({24'd0, b}, bad);
                    return;
                end
                if (b >= LEAD2_LO && b <= LEAD2_HI)
                begin
                    acc_cp   = {27'd0, b[4:0]};
                    unit_len = 3'd2;
                end
                else if (b >= LEAD3_LO && b <= LEAD3_HI)
                begin
                    acc_cp   = {28'd0, b[3:0]};
                    unit_len = 3'd3;
                end
                else if (b >= LEAD4_LO && b <= LEAD4_HI)
                begin
                    acc_cp   = {29'd0, b[2:0]};
                    unit_len = 3'd4;
                end
                else
                begin
                    bad = 1'b1;
                    return;
                end
                unit_pos = 3'd1;
                return;
            end
            if (b[7:6] != 2'b10)
            begin
                bad = 1'b1;
                return;
            end
            acc_cp = {acc_cp[25:0], b[5:0]};
        end
        else if (tag == TAG_BMP || tag == TAG_UNIV)
        begin
            if (unit_pos == 0)
            begin
                acc_cp   = {24'd0, b};
                unit_len = (tag == TAG_BMP) ? 3'd2 : 3'd4;
                unit_pos = 3'd1;
                return;
            end
            acc_cp = {acc_cp[23:0], b};
        end
        else if (tag == TAG_PRINT || tag == TAG_T61 || tag == TAG_IA5)
        begin
            // a one-byte tag cannot finish a unit begun under another tag
            if (unit_pos != 0)
                bad = 1'b1;
            else
                store_code_point({24'd0, b}, bad);
            return;
        end
        else
        begin
            bad = 1'b1;
            return;
        end
        unit_pos++;
        if (unit_pos < unit_len)
            return;
        unit_pos = '0;
        // overlong forms only count when the completing byte is UTF-8 tagged
        if (tag == TAG_UTF8 && ((unit_len == 3'd2 && acc_cp <= CP_ONE_MAX) ||
                                (unit_len == 3'd3 && acc_cp <= CP_TWO_MAX) ||
                                (unit_len == 3'd4 && acc_cp <= CP_THREE_MAX)))
        begin
            bad = 1'b1;
            return;
        end
        store_code_point(acc_cp, bad);
    endtask

    task automatic predict_transcode(input str_item_t it);
        utf8_res_t r;
        bit        bad;
        bit        ending;
        run_q.delete();
        ending = 1'b0;
        if (it.empty)
        begin
            ending = 1'b1;
            if (!(it.tag == TAG_UTF8 || it.tag == TAG_BMP || it.tag == TAG_UNIV ||
                  it.tag == TAG_PRINT || it.tag == TAG_T61 || it.tag == TAG_IA5))
                str_bad = 1'b1;
        end
        else
        begin
            if (!str_bad)
            begin
                take_content_byte(it.tag, it.data, bad);
                if (bad)
                begin
                    str_bad = 1'b1;
                    run_q.delete();
                end
            end
            if (it.last)
                ending = 1'b1;
        end
        if (ending)
        begin
            if (unit_pos != 0)
                str_bad = 1'b1;
            r = '0;
            r.done_res   = 1'b1;
            r.status     = str_bad;
            r.total_size = str_bad ? 7'd0 : out_count;
            run_q.push_back(r);
            reset_decoder();
        end
        if (run_q.size() > 0)
        begin
            r = run_q.pop_back();
            r.last_of_run = 1'b1;
            run_q.push_back(r);
        end
        foreach (run_q[i])
            utf8_expect_q.push_back(run_q[i]);
    endtask

    // ---------------------------------------------------------------- checker

    always @(posedge clk)
    begin : check_results
        utf8_res_t got;
        utf8_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.out_byte    = m_axis_tdata[7:0];
            got.out_index   = m_axis_tdata[14:8];
            got.status      = m_axis_tdata[15];
            got.total_size  = m_axis_tdata[22:16];
            got.byte_valid  = m_axis_tuser[0];
            got.done_res    = m_axis_tuser[1];
            got.last_of_run = m_axis_tlast;
            if (utf8_expect_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 40)
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end
            else
            begin
                want = utf8_expect_q.pop_front();
                if (got !== want || m_axis_tdata[23] !== 1'b0)
                begin
                    mismatch_count++;
                    // fields from the top: byte, idx, bv, last, done, st, size
                    if (mismatch_count <= 40)
                        $display("%0t: mismatch expected %h pad 0, actual %h pad %b",
                                 $time, want, got, m_axis_tdata[23]);
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    initial
    begin : result_sink
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 17) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- sender

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input str_item_t it);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.data;
        s_axis_tlast  <= it.last;
        s_axis_tuser  <= {it.empty, it.tag};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_transcode(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (utf8_expect_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic add_item(input logic [7:0] tag, input logic [7:0] data,
                            input logic last, input logic empty);
        str_item_t it;
        it.tag   = tag;
        it.data  = data;
        it.last  = last;
        it.empty = empty;
        stim_q.push_back(it);
    endtask

    task automatic add_byte(input logic [7:0] tag, input logic [7:0] data);
        add_item(tag, data, 1'b0, 1'b0);
    endtask

    // Appends the content bytes of one code point under the given tag.
    task automatic add_cp(input logic [7:0] tag, input logic [31:0] cp);
        logic [31:0] enc;
        int          len;
        if (tag == TAG_UTF8)
        begin
            len = utf8_encode(cp, enc);
            for (int i = 0; i < len; i++)
                add_byte(tag, enc[8*i +: 8]);
        end
        else if (tag == TAG_BMP)
        begin
            add_byte(tag, cp[15:8]);
            add_byte(tag, cp[7:0]);
        end
        else if (tag == TAG_UNIV)
        begin
            add_byte(tag, cp[31:24]);
            add_byte(tag, cp[23:16]);
            add_byte(tag, cp[15:8]);
            add_byte(tag, cp[7:0]);
        end
        else
            add_byte(tag, cp[7:0]);
    endtask

    // Sends the queued items (a random IA5 byte if none); mark_last sets tlast on the final one.
    task automatic flush_string(input bit mark_last);
        str_item_t it;
        if (stim_q.size() == 0)
            add_byte(TAG_IA5, 8'($urandom_range(0, 255)));
        if (mark_last)
        begin
            it = stim_q.pop_back();
            it.last = 1'b1;
            stim_q.push_back(it);
        end
        foreach (stim_q[i])
            send_item(stim_q[i]);
        stim_q.delete();
    endtask

    function automatic logic [7:0] pick_known_tag();
        case ($urandom_range(0, 5))
            0: return TAG_UTF8;
            1: return TAG_BMP;
            2: return TAG_UNIV;
            3: return TAG_PRINT;
            4: return TAG_T61;
            default: return TAG_IA5;
        endcase
    endfunction

    function automatic logic [31:0] rand_cp(input int cls);
        case (cls)
            0: return $urandom_range(0, 'h7F);
            1: return $urandom_range('h80, 'h7FF);
            2: return $urandom_range('h800, 'hFFFF);
            3: return $urandom_range('h10000, 'h10FFFF);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] well_formed_cp(input logic [7:0] tag);
        logic [31:0] cp;
        if (tag == TAG_UTF8 || tag == TAG_UNIV)
            cp = rand_cp($urandom_range(0, 3));
        else if (tag == TAG_BMP)
            cp = rand_cp($urandom_range(0, 2));
        else
            cp = $urandom_range(0, 255);
        // mostly steer away from surrogates; UTF-8 cannot carry them at all
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI &&
            (tag == TAG_UTF8 || $urandom_range(0, 7) != 0))
            cp = cp ^ 32'h8000;
        return cp;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_utf8_forms();
        add_byte(TAG_UTF8, 8'h7F);
        add_byte(TAG_UTF8, 8'hC2);
        add_byte(TAG_UTF8, 8'h80);
        add_byte(TAG_UTF8, 8'hF4);
        add_byte(TAG_UTF8, 8'h8F);
        add_byte(TAG_UTF8, 8'hBF);
        add_byte(TAG_UTF8, 8'hBF);
        flush_string(1'b1);
    endtask

    task automatic test_utf8_errors();
        // bad lead, then the rest of the string is swallowed
        add_byte(TAG_UTF8, 8'hC0);
        add_byte(TAG_UTF8, 8'h41);
        flush_string(1'b1);
        // overlong three-byte form
        add_byte(TAG_UTF8, 8'hE0);
        add_byte(TAG_UTF8, 8'h80);
        add_byte(TAG_UTF8, 8'h80);
        flush_string(1'b1);
        // encoded surrogate
        add_byte(TAG_UTF8, 8'hED);
        add_byte(TAG_UTF8, 8'hA0);
        add_byte(TAG_UTF8, 8'h80);
        flush_string(1'b1);
        // continuation byte missing
        add_byte(TAG_UTF8, 8'hC3);
        add_byte(TAG_UTF8, 8'h41);
        flush_string(1'b1);
        // sequence cut off at the string end
        add_byte(TAG_UTF8, 8'hE2);
        add_byte(TAG_UTF8, 8'h82);
        flush_string(1'b1);
    endtask

    task automatic test_bmp_universal();
        add_cp(TAG_BMP, 32'h0041);
        add_cp(TAG_BMP, 32'hD800);
        flush_string(1'b1);
        // odd BMP length
        add_byte(TAG_BMP, 8'hFF);
        flush_string(1'b1);
        add_cp(TAG_UNIV, CP_MAX);
        flush_string(1'b1);
        add_cp(TAG_UNIV, CP_MAX + 1);
        flush_string(1'b1);
    endtask

    task automatic test_single_byte();
        add_byte(TAG_PRINT, 8'h00);
        add_byte(TAG_T61, 8'hFF);
        add_byte(TAG_IA5, 8'h80);
        flush_string(1'b1);
    endtask

    task automatic test_empty_and_unknown();
        add_item(TAG_UTF8, 8'h00, 1'b0, 1'b1);
        flush_string(1'b0);
        add_item(TAG_UNKNOWN_HI, 8'hFF, 1'b1, 1'b1);
        flush_string(1'b0);
        add_byte(TAG_UNKNOWN_LO, 8'h41);
        flush_string(1'b1);
        // both marks with a BMP unit half done
        add_byte(TAG_BMP, 8'h12);
        add_item(TAG_BMP, 8'h34, 1'b1, 1'b1);
        flush_string(1'b0);
    endtask

    task automatic test_tag_change();
        add_byte(TAG_UTF8, 8'hE2);
        add_byte(TAG_BMP, 8'h82);
        add_byte(TAG_UTF8, 8'hAC);
        flush_string(1'b1);
        add_byte(TAG_BMP, 8'h00);
        add_byte(TAG_IA5, 8'h41);
        flush_string(1'b1);
    endtask

    // High single-byte values expand to two bytes and overrun the buffer.
    task automatic test_capacity();
        repeat (66)
            add_byte(TAG_T61, 8'($urandom_range(8'h80, 8'hFF)));
        flush_string(1'b1);
    endtask

    task automatic send_random_string();
        str_item_t   it;
        logic [7:0]  tag;
        int          kind;
        int          units;
        int          pos;
        kind  = $urandom_range(0, 15);
        units = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
        if (kind < 9)
        begin
            tag = pick_known_tag();
            repeat (units)
                add_cp(tag, well_formed_cp(tag));
        end
        else if (kind < 11)
        begin
            repeat (units)
            begin
                tag = pick_known_tag();
                add_cp(tag, well_formed_cp(tag));
            end
        end
        else if (kind == 11)
        begin
            // valid UTF-8 that may be cut short and has one byte replaced
            repeat (units)
                add_cp(TAG_UTF8, well_formed_cp(TAG_UTF8));
            if ($urandom_range(0, 1) == 0)
                void'(stim_q.pop_back());
            if (stim_q.size() > 0)
            begin
                pos = $urandom_range(0, stim_q.size() - 1);
                it = stim_q[pos];
                it.data = 8'($urandom_range(0, 255));
                stim_q[pos] = it;
            end
        end
        else if (kind == 12)
        begin
            repeat (units)
            begin
                tag = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : pick_known_tag();
                add_byte(tag, 8'($urandom_range(0, 255)));
            end
        end
        else if (kind == 13)
        begin
            if ($urandom_range(0, 1) == 0)
                add_cp(TAG_UNIV, rand_cp($urandom_range(3, 4)));
            else
                add_cp(TAG_BMP, $urandom_range(0, 'hFFFF));
        end
        else
        begin
            // string closed by an empty-string item, maybe with a unit pending
            repeat ($urandom_range(0, 2))
                add_byte(pick_known_tag(), 8'($urandom_range(0, 255)));
            tag = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : pick_known_tag();
            add_item(tag, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            flush_string(1'b0);
            return;
        end
        flush_string(1'b1);
    endtask

    task automatic test_random_strings();
        int stop_at;
        stop_at = items_sent + RAND_ITEMS;
        test_capacity();
        while (items_sent < stop_at)
        begin
            idle_on = (items_sent < stop_at - QUIET_TAIL);
            send_random_string();
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        s_axis_tuser   = '0;
        idle_on        = 1'b1;
        mismatch_count = 0;
        items_sent     = 0;
        reset_decoder();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_utf8_forms();
        test_utf8_errors();
        wait_drain();
        test_bmp_universal();
        test_single_byte();
        wait_drain();
        test_empty_and_unknown();
        test_tag_change();
        wait_drain();
        test_random_strings();

        wait_drain();
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
